### hw/rtl/bpl_pkg.sv
// Shared types and constants for the bounded positional list.
// Holds the item structs, the action and status codes and the cell control struct.
// No dependencies.
`default_nettype none

package bpl_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [2:0] {
        ACT_INSERT_FRONT = 3'd0,
        ACT_INSERT_AFTER = 3'd1,
        ACT_INSERT_END   = 3'd2,
        ACT_DELETE       = 3'd3,
        ACT_LIST         = 3'd4
    } action_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_e;

    typedef enum logic {
        STATE_IDLE,
        STATE_LIST
    } state_e;

    typedef struct packed {
        logic [2:0]         action;
        logic [4:0]         position;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_position;
        logic [4:0]         entry_count;
        logic               last;
    } response_t;

    typedef struct packed {
        cell_op_e          op;
        logic [CNT_W-1:0]  at;
        logic [CNT_W-1:0]  count;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/bpl_cell.sv
// One storage cell of the list chain.
// Depends on bpl_pkg for the cell control struct and widths.
`default_nettype none

module bpl_cell
    import bpl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [CNT_W-1:0]   index,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic signed [31:0] new_value,
    input  wire logic signed [31:0] left,
    input  wire logic signed [31:0] right,
    input  wire logic signed [31:0] head,
    output logic signed [31:0]      value
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic [CNT_W-1:0]   tail_idx;

    assign tail_idx = CNT_W'(ctrl.count - 1'b1);

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (index == ctrl.at)
                begin
                    value_next = new_value;
                end
                else if (index > ctrl.at)
                begin
                    value_next = left;
                end
            end
            CELL_DELETE:
            begin
                if (index >= ctrl.at)
                begin
                    value_next = right;
                end
            end
            CELL_ROTATE:
            begin
                if (index == tail_idx)
                begin
                    value_next = head;
                end
                else if (index < tail_idx)
                begin
                    value_next = right;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### hw/rtl/bounded_positional_list_top.sv
// Top level of the bounded positional list: control, count and the chain of cells.
// Depends on bpl_pkg and bpl_cell.
`default_nettype none

// The block holds up to 16 signed 32-bit entries in a chain of cells. An edit
// item (insert or delete) is taken and its single result appears on the next
// cycle, with busy staying low, so edits can be issued every cycle while idle.
// A list item of a list with N entries keeps busy high while the chain rotates
// once around, one entry per cycle from the front; each result is registered and
// appears in the cycle after its entry is read, one per cycle, the final one
// marked by last. A list item on an empty list answers with a single empty
// status. Results are shown for one cycle under strobe and cannot be held off.
module bounded_positional_list_top
    import bpl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire request_t  request,
    output logic           strobe,
    output response_t      response
);

    state_e             state_reg;
    state_e             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic               strobe_reg;
    logic               strobe_next;
    response_t          response_reg;
    response_t          response_next;

    cell_ctrl_t         ctrl;
    logic signed [31:0] cell_value [DEPTH];
    logic               accept;
    logic               pos_ok;
    logic               list_end;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;

    assign busy     = (state_reg == STATE_LIST);
    assign accept   = start && !busy;
    assign pos_ext  = CMP_W'(request.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign list_end = (idx_reg == CNT_W'(count_reg - 1'b1));

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic signed [31:0] left_in;
            logic signed [31:0] right_in;

            if (k == 0)
            begin : g_first
                assign left_in = request.value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_value[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_final
                assign right_in = cell_value[k];
            end
            else
            begin : g_mid_r
                assign right_in = cell_value[k+1];
            end

            bpl_cell u_cell (
                .clk       (clk),
                .index     (CNT_W'(k)),
                .ctrl      (ctrl),
                .new_value (request.value),
                .left      (left_in),
                .right     (right_in),
                .head      (cell_value[0]),
                .value     (cell_value[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            STATE_IDLE:
            begin
                if (accept && (request.action == ACT_LIST) && (count_reg != '0))
                begin
                    state_next = STATE_LIST;
                end
            end
            STATE_LIST:
            begin
                if (list_end)
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.op       = CELL_HOLD;
        ctrl.at       = '0;
        ctrl.count    = count_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        strobe_next   = 1'b0;
        response_next = response_reg;

        if (state_reg == STATE_LIST)
        begin
            ctrl.op                      = CELL_ROTATE;
            strobe_next                  = 1'b1;
            response_next.status         = ST_OK;
            response_next.entry_value    = cell_value[0];
            response_next.entry_position = 5'(idx_reg + 1'b1);
            response_next.entry_count    = 5'(count_reg);
            response_next.last           = list_end;
            idx_next                     = CNT_W'(idx_reg + 1'b1);
        end
        else if (accept)
        begin
            response_next.status         = ST_OK;
            response_next.entry_value    = '0;
            response_next.entry_position = '0;
            response_next.last           = 1'b1;
            strobe_next                  = 1'b1;
            case (request.action)
                ACT_INSERT_FRONT, ACT_INSERT_AFTER, ACT_INSERT_END:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        response_next.status = ST_FULL;
                    end
                    else if ((count_reg == '0) || (request.action == ACT_INSERT_FRONT))
                    begin
                        ctrl.op    = CELL_INSERT;
                        ctrl.at    = '0;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else if (request.action == ACT_INSERT_END)
                    begin
                        ctrl.op    = CELL_INSERT;
                        ctrl.at    = count_reg;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else if (pos_ok)
                    begin
                        ctrl.op    = CELL_INSERT;
                        ctrl.at    = CNT_W'(request.position);
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        response_next.status = ST_RANGE;
                    end
                end
                ACT_DELETE:
                begin
                    if (count_reg == '0)
                    begin
                        response_next.status = ST_EMPTY;
                    end
                    else if (pos_ok)
                    begin
                        ctrl.op    = CELL_DELETE;
                        ctrl.at    = CNT_W'(request.position - 1'b1);
                        count_next = CNT_W'(count_reg - 1'b1);
                    end
                    else
                    begin
                        response_next.status = ST_RANGE;
                    end
                end
                ACT_LIST:
                begin
                    if (count_reg == '0)
                    begin
                        response_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        strobe_next = 1'b0;
                        idx_next    = '0;
                    end
                end
                default:
                begin
                    response_next.status = ST_OK;
                end
            endcase
            response_next.entry_count = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        response_reg <= response_next;
    end

    assign strobe   = strobe_reg;
    assign response = response_reg;

    a_busy_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != '0))
        else $error("List run active with an empty list.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("Entry count changed without an accepted item.");

    a_list_run_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && response.last))
        else $error("List run ended without a final marked result.");

endmodule

`default_nettype wire

### dv/tb_bounded_positional_list_top.sv
// Self-checking testbench for bounded_positional_list_top: directed and random edit and list items.
// Responses are predicted in the bench and compared with the block's outputs.
// Depends on bpl_pkg and the bounded_positional_list_top RTL.
`default_nettype none

module tb_bounded_positional_list_top;
    import bpl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    request_t  request = '0;
    logic      strobe;
    response_t response;

    request_t           pending_requests[$];
    response_t          awaited_responses[$];
    logic signed [31:0] model_cells[DEPTH];
    int                 model_held = 0;
    int                 planned_held = 0;
    int                 send_idle_pct = 0;
    int                 errors = 0;
    int                 cycles = 0;
    logic               item_taken = 1'b0;

    bounded_positional_list_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .strobe   (strobe),
        .response (response)
    );

    always #10 clk = ~clk;

    function automatic string describe(input response_t r);
        return $sformatf("status=%0d value=%0d pos=%0d count=%0d last=%0b",
                         r.status, r.entry_value, r.entry_position, r.entry_count, r.last);
    endfunction

    task automatic apply_request(input request_t req);
        response_t resp;
        status_e   st;
        int        slot;
        st = ST_OK;
        resp = '0;
        case (req.action)
            ACT_INSERT_FRONT, ACT_INSERT_AFTER, ACT_INSERT_END:
            begin
                slot = -1;
                if (model_held >= DEPTH)
                    st = ST_FULL;
                else if (model_held == 0 || req.action == ACT_INSERT_FRONT)
                    slot = 0;
                else if (req.action == ACT_INSERT_END)
                    slot = model_held;
                else if (req.position >= 1 && req.position <= model_held)
                    slot = req.position;
                else
                    st = ST_RANGE;
                if (slot >= 0)
                begin
                    for (int i = model_held; i > slot; i--)
                        model_cells[i] = model_cells[i - 1];
                    model_cells[slot] = req.value;
                    model_held++;
                end
            end
            ACT_DELETE:
            begin
                if (model_held == 0)
                    st = ST_EMPTY;
                else if (req.position >= 1 && req.position <= model_held)
                begin
                    for (int i = req.position - 1; i + 1 < model_held; i++)
                        model_cells[i] = model_cells[i + 1];
                    model_held--;
                end
                else
                    st = ST_RANGE;
            end
            ACT_LIST:
            begin
                if (model_held == 0)
                    st = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < model_held; i++)
                    begin
                        resp.status = ST_OK;
                        resp.entry_value = model_cells[i];
                        resp.entry_position = 5'(i + 1);
                        resp.entry_count = 5'(model_held);
                        resp.last = (i + 1 == model_held);
                        awaited_responses.push_back(resp);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        resp.status = st;
        resp.entry_count = 5'(model_held);
        resp.last = 1'b1;
        awaited_responses.push_back(resp);
    endtask

    // The planned count follows the list size the queued items will leave behind,
    // so that random positions can be aimed inside the list most of the time.
    task automatic plan_item(input logic [2:0] act, input logic [4:0] pos,
                             input logic signed [31:0] val);
        request_t req;
        req.action = act;
        req.position = pos;
        req.value = val;
        pending_requests.push_back(req);
        if (act == ACT_INSERT_FRONT || act == ACT_INSERT_END || act == ACT_INSERT_AFTER)
        begin
            if (planned_held < DEPTH && (planned_held == 0 || act != ACT_INSERT_AFTER
                                         || (pos >= 1 && pos <= planned_held)))
                planned_held++;
        end
        else if (act == ACT_DELETE && pos >= 1 && pos <= planned_held)
            planned_held--;
    endtask

    task automatic plan_random(input int insert_pct);
        int                 pick;
        logic [2:0]         act;
        logic [4:0]         pos;
        logic signed [31:0] val;
        pick = $urandom_range(99);
        if (pick < insert_pct)
        begin
            case ($urandom_range(2))
                0: act = ACT_INSERT_FRONT;
                1: act = ACT_INSERT_AFTER;
                default: act = ACT_INSERT_END;
            endcase
        end
        else if (pick < 88)
            act = ACT_DELETE;
        else if (pick < 96)
            act = ACT_LIST;
        else
            act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        if (planned_held > 0 && $urandom_range(9) < 8)
            pos = 5'($urandom_range(planned_held, 1));
        else
            pos = 5'($urandom_range(31, 0));
        case ($urandom_range(9))
            0: val = 32'sh8000_0000;
            1: val = 32'sh7fff_ffff;
            2: val = -32'sd1;
            3: val = '0;
            default: val = $urandom;
        endcase
        plan_item(act, pos, val);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || start || awaited_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct);
        send_idle_pct = idle_pct;
        while (planned_held < DEPTH)
            plan_random(100);
        plan_random(100);
        plan_random(100);
        plan_item(ACT_LIST, 5'($urandom), $urandom);
        repeat (25)
            plan_random(45);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || item_taken)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                request <= pending_requests.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        response_t want;
        item_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (awaited_responses.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response %s", $time, describe(response));
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (response.status !== want.status
                        || response.entry_value !== want.entry_value
                        || response.entry_position !== want.entry_position
                        || response.entry_count !== want.entry_count
                        || response.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %s actual %s", $time,
                                 describe(want), describe(response));
                    end
                end
            end
            if (start && !busy)
                apply_request(request);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("tb_bounded_positional_list_top failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        plan_item(ACT_LIST, 5'd0, '0);
        plan_item(ACT_DELETE, 5'd1, '0);
        plan_item(ACT_INSERT_AFTER, 5'd0, 32'sh8000_0000);
        plan_item(ACT_INSERT_FRONT, 5'd31, 32'sh7fff_ffff);
        plan_item(ACT_INSERT_END, 5'd0, -32'sd1);
        plan_item(ACT_INSERT_AFTER, 5'd0, 32'sh1234_5678);
        plan_item(ACT_INSERT_AFTER, 5'd3, 32'sh5a5a_a5a5);
        plan_item(ACT_INSERT_AFTER, 5'd31, 32'sh0bad_cafe);
        plan_item(ACT_INSERT_AFTER, 5'd5, 32'sh0000_0001);
        plan_item(ACT_DELETE, 5'd0, '0);
        plan_item(ACT_DELETE, 5'd31, '0);
        plan_item(ACT_DELETE, 5'd5, '0);
        plan_item(ACT_DELETE, 5'd1, '0);
        plan_item(ACT_SPARE_LO, 5'd1, 32'sh1111_1111);
        plan_item(ACT_SPARE_MID, 5'd2, 32'sh2222_2222);
        plan_item(ACT_SPARE_HI, 5'd3, 32'sh3333_3333);
        plan_item(ACT_LIST, 5'd0, '0);
        plan_item(ACT_DELETE, 5'd3, '0);
        plan_item(ACT_LIST, 5'd31, 32'shffff_ffff);
        wait_drained();

        run_phase(0);
        run_phase(85);
        run_phase(0);
        run_phase(21);

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (awaited_responses.size() != 0)
        begin
            errors++;
            $display("%0t: %0d responses never arrived, next expected %s", $time,
                     awaited_responses.size(), describe(awaited_responses[0]));
        end
        if (errors == 0)
            $display("tb_bounded_positional_list_top passed");
        else
            $display("tb_bounded_positional_list_top failed");
        $finish;
    end

endmodule

`default_nettype wire
